@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame parser checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every rising edge outside reset
`define SFSP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check prop at every rising edge, reset included
`define SFSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/sfsp_pkg.sv @@
// ----------------------------------------------------------------------------
// Frame parser package
// Transaction types, field and error codes and register defaults.
// ----------------------------------------------------------------------------
package sfsp_pkg;

  typedef enum logic [3:0] {
    FK_FORMAT      = 4'd0,
    FK_COUNT       = 4'd1,
    FK_ID_LENGTH   = 4'd2,
    FK_ID_BYTE     = 4'd3,
    FK_ENTRY_STATE = 4'd4,
    FK_TIMESTAMP   = 4'd5,
    FK_HELD_COUNT  = 4'd6,
    FK_VERDICT_OK  = 4'd7,
    FK_VERDICT_ERR = 4'd8
  } field_kind_t;

  typedef enum logic [2:0] {
    CAUSE_NONE      = 3'd0,
    CAUSE_TRUNCATED = 3'd1,
    CAUSE_OVER_CNT  = 3'd2,
    CAUSE_ID_LONG   = 3'd3,
    CAUSE_TRAILING  = 3'd4
  } error_cause_t;

  typedef enum logic [1:0] {
    CFG_FRAME_KIND    = 2'd0,
    CFG_MAX_ENTRIES   = 2'd1,
    CFG_MAX_LIST_IDS  = 2'd2,
    CFG_MAX_ID_LENGTH = 2'd3
  } cfg_index_t;

  localparam int          CFG_DATA_W        = 16;
  localparam logic [15:0] MAX_ENTRIES_RST   = 16'd1024;
  localparam logic [15:0] MAX_LIST_IDS_RST  = 16'd256;
  localparam logic [9:0]  MAX_ID_LENGTH_RST = 10'd600;
  localparam int          QUEUE_DEPTH       = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    field_kind_t  field_kind;
    logic [63:0]  field_value;
    logic [15:0]  entry_index;
    logic         in_held_list;
    error_cause_t error_cause;
    logic         frame_last;
  } out_item_t;

  typedef struct packed {
    logic      first_valid;
    logic      second_valid;
    out_item_t first_item;
    out_item_t second_item;
  } res_pair_t;

endpackage

@@ src/sfsp_core.sv @@
// ----------------------------------------------------------------------------
// Frame parser core
// Parse state, configuration registers and per-byte next-state logic.
// ----------------------------------------------------------------------------
module sfsp_core #(
  parameter int COUNT_LIMIT     = 65535,
  parameter int ID_LENGTH_LIMIT = 1023
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              take_i,
  input  sfsp_pkg::in_item_t                item_i,
  input  logic                              cfg_we_i,
  input  sfsp_pkg::cfg_index_t              cfg_index_i,
  input  logic [sfsp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output sfsp_pkg::res_pair_t               push_o
);
  import sfsp_pkg::*;

  typedef enum logic [11:0] {
    PH_START  = 12'b0000_0000_0001,
    PH_FORMAT = 12'b0000_0000_0010,
    PH_ICOUNT = 12'b0000_0000_0100,
    PH_ILEN   = 12'b0000_0000_1000,
    PH_IBYTES = 12'b0000_0001_0000,
    PH_ISTATE = 12'b0000_0010_0000,
    PH_ITS    = 12'b0000_0100_0000,
    PH_WCOUNT = 12'b0000_1000_0000,
    PH_HCOUNT = 12'b0001_0000_0000,
    PH_WLEN   = 12'b0010_0000_0000,
    PH_WBYTES = 12'b0100_0000_0000,
    PH_DONE   = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] index;
    logic [15:0] remaining;
  } fin_t;

  localparam logic [15:0] CNT_CAP = 16'(COUNT_LIMIT);
  localparam logic [15:0] ID_CAP  = 16'(ID_LENGTH_LIMIT);

  function automatic fin_t finish_item(input logic [15:0] idx, input logic [15:0] rem,
                                       input logic lsel, input logic inv);
    fin_t f;
    f.index     = idx + 16'd1;
    f.remaining = rem - 16'd1;
    if (f.remaining == 16'd0) begin
      f.phase = (inv || lsel) ? PH_DONE : PH_HCOUNT;
    end else begin
      f.phase = inv ? PH_ILEN : PH_WLEN;
    end
    return f;
  endfunction

  logic        frame_kind_r;
  logic [15:0] max_entries_r;
  logic [15:0] max_list_ids_r;
  logic [9:0]  max_id_length_r;

  phase_t      phase_r,   phase_nxt;
  logic [2:0]  bif_r,     bif_nxt;
  logic [63:0] acc_r,     acc_nxt;
  logic [15:0] items_r,   items_nxt;
  logic [9:0]  idrem_r,   idrem_nxt;
  logic [15:0] idx_r,     idx_nxt;
  logic        lsel_r,    lsel_nxt;
  logic        discard_r, discard_nxt;

  logic [15:0]  lim_e, lim_w, lim_id, lim_cnt;
  logic [31:0]  word;
  logic         held;
  fin_t         fin;
  logic         f_v, v_v;
  out_item_t    f_item, v_item;
  error_cause_t cause;

  assign lim_e   = (max_entries_r < CNT_CAP) ? max_entries_r : CNT_CAP;
  assign lim_w   = (max_list_ids_r < CNT_CAP) ? max_list_ids_r : CNT_CAP;
  assign lim_id  = ({6'd0, max_id_length_r} < ID_CAP) ? {6'd0, max_id_length_r} : ID_CAP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_kind_r    <= 1'b0;
      max_entries_r   <= MAX_ENTRIES_RST;
      max_list_ids_r  <= MAX_LIST_IDS_RST;
      max_id_length_r <= MAX_ID_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_KIND:    frame_kind_r    <= cfg_data_i[0];
        CFG_MAX_ENTRIES:   max_entries_r   <= cfg_data_i[15:0];
        CFG_MAX_LIST_IDS:  max_list_ids_r  <= cfg_data_i[15:0];
        CFG_MAX_ID_LENGTH: max_id_length_r <= cfg_data_i[9:0];
        default:           frame_kind_r    <= frame_kind_r;
      endcase
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    bif_nxt     = bif_r;
    acc_nxt     = acc_r;
    items_nxt   = items_r;
    idrem_nxt   = idrem_r;
    idx_nxt     = idx_r;
    lsel_nxt    = lsel_r;
    discard_nxt = discard_r;
    cause       = CAUSE_NONE;
    f_v         = 1'b0;
    v_v         = 1'b0;
    f_item      = '0;
    v_item      = '0;
    word        = '0;
    held        = 1'b0;
    lim_cnt     = lim_w;
    fin         = '0;
    if (take_i) begin
      if (discard_r) begin
        if (item_i.frame_end) begin
          discard_nxt = 1'b0;
          phase_nxt   = PH_START;
        end
      end else begin
        if (phase_r == PH_START) begin
          phase_nxt = frame_kind_r ? PH_WCOUNT : PH_FORMAT;
          bif_nxt   = '0;
          acc_nxt   = '0;
          items_nxt = '0;
          idrem_nxt = '0;
          idx_nxt   = '0;
          lsel_nxt  = 1'b0;
        end
        if (phase_nxt == PH_DONE) begin
          cause = CAUSE_TRAILING;
        end else begin
          acc_nxt = {acc_nxt[55:0], item_i.data_byte};
          word    = acc_nxt[31:0];
          case (phase_nxt)
            PH_FORMAT: begin
              f_v                = 1'b1;
              f_item.field_kind  = FK_FORMAT;
              f_item.field_value = {56'd0, item_i.data_byte};
              acc_nxt            = '0;
              phase_nxt          = PH_ICOUNT;
            end
            PH_ICOUNT, PH_WCOUNT, PH_HCOUNT: begin
              if (bif_nxt < 3'd3) begin
                bif_nxt = bif_nxt + 3'd1;
              end else begin
                bif_nxt             = '0;
                held                = (phase_nxt == PH_HCOUNT);
                lim_cnt             = (phase_nxt == PH_ICOUNT) ? lim_e : lim_w;
                acc_nxt             = '0;
                f_v                 = 1'b1;
                f_item.field_kind   = held ? FK_HELD_COUNT : FK_COUNT;
                f_item.field_value  = {32'd0, word};
                f_item.in_held_list = held;
                if (word > {16'd0, lim_cnt}) begin
                  cause = CAUSE_OVER_CNT;
                end else begin
                  lsel_nxt  = held;
                  items_nxt = word[15:0];
                  idx_nxt   = '0;
                  if (word == 32'd0) begin
                    phase_nxt = (phase_nxt == PH_WCOUNT) ? PH_HCOUNT : PH_DONE;
                  end else begin
                    phase_nxt = (phase_nxt == PH_ICOUNT) ? PH_ILEN : PH_WLEN;
                  end
                end
              end
            end
            PH_ILEN, PH_WLEN: begin
              if (bif_nxt < 3'd3) begin
                bif_nxt = bif_nxt + 3'd1;
              end else begin
                bif_nxt             = '0;
                acc_nxt             = '0;
                f_v                 = 1'b1;
                f_item.field_kind   = FK_ID_LENGTH;
                f_item.field_value  = {32'd0, word};
                f_item.entry_index  = idx_nxt;
                f_item.in_held_list = lsel_nxt;
                if (word > {16'd0, lim_id}) begin
                  cause = CAUSE_ID_LONG;
                end else begin
                  idrem_nxt = word[9:0];
                  if (word != 32'd0) begin
                    phase_nxt = (phase_nxt == PH_ILEN) ? PH_IBYTES : PH_WBYTES;
                  end else if (phase_nxt == PH_ILEN) begin
                    phase_nxt = PH_ISTATE;
                  end else begin
                    fin       = finish_item(idx_nxt, items_nxt, lsel_nxt, 1'b0);
                    idx_nxt   = fin.index;
                    items_nxt = fin.remaining;
                    phase_nxt = fin.phase;
                  end
                end
              end
            end
            PH_IBYTES, PH_WBYTES: begin
              acc_nxt             = '0;
              f_v                 = 1'b1;
              f_item.field_kind   = FK_ID_BYTE;
              f_item.field_value  = {56'd0, item_i.data_byte};
              f_item.entry_index  = idx_nxt;
              f_item.in_held_list = lsel_nxt;
              idrem_nxt           = idrem_nxt - 10'd1;
              if (idrem_nxt == 10'd0) begin
                if (phase_nxt == PH_IBYTES) begin
                  phase_nxt = PH_ISTATE;
                end else begin
                  fin       = finish_item(idx_nxt, items_nxt, lsel_nxt, 1'b0);
                  idx_nxt   = fin.index;
                  items_nxt = fin.remaining;
                  phase_nxt = fin.phase;
                end
              end
            end
            PH_ISTATE: begin
              acc_nxt            = '0;
              f_v                = 1'b1;
              f_item.field_kind  = FK_ENTRY_STATE;
              f_item.field_value = {56'd0, item_i.data_byte};
              f_item.entry_index = idx_nxt;
              phase_nxt          = PH_ITS;
            end
            PH_ITS: begin
              if (bif_nxt < 3'd7) begin
                bif_nxt = bif_nxt + 3'd1;
              end else begin
                bif_nxt            = '0;
                f_v                = 1'b1;
                f_item.field_kind  = FK_TIMESTAMP;
                f_item.field_value = acc_nxt;
                f_item.entry_index = idx_nxt;
                acc_nxt            = '0;
                fin                = finish_item(idx_nxt, items_nxt, lsel_nxt, 1'b1);
                idx_nxt            = fin.index;
                items_nxt          = fin.remaining;
                phase_nxt          = fin.phase;
              end
            end
            default: begin
              cause = CAUSE_TRAILING;
            end
          endcase
        end
        if (cause != CAUSE_NONE) begin
          v_v                = 1'b1;
          v_item.field_kind  = FK_VERDICT_ERR;
          v_item.error_cause = cause;
          v_item.frame_last  = 1'b1;
          discard_nxt        = !item_i.frame_end;
          phase_nxt          = PH_START;
        end else if (item_i.frame_end) begin
          v_v                = 1'b1;
          v_item.frame_last  = 1'b1;
          if (phase_nxt == PH_DONE) begin
            v_item.field_kind = FK_VERDICT_OK;
          end else begin
            v_item.field_kind  = FK_VERDICT_ERR;
            v_item.error_cause = CAUSE_TRUNCATED;
          end
          phase_nxt = PH_START;
        end
      end
    end
  end

  always_comb begin
    push_o = '0;
    if (f_v) begin
      push_o.first_valid  = 1'b1;
      push_o.first_item   = f_item;
      push_o.second_valid = v_v;
      push_o.second_item  = v_item;
    end else begin
      push_o.first_valid  = v_v;
      push_o.first_item   = v_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      bif_r     <= '0;
      items_r   <= '0;
      idrem_r   <= '0;
      idx_r     <= '0;
      lsel_r    <= 1'b0;
      discard_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      bif_r     <= bif_nxt;
      items_r   <= items_nxt;
      idrem_r   <= idrem_nxt;
      idx_r     <= idx_nxt;
      lsel_r    <= lsel_nxt;
      discard_r <= discard_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

endmodule

@@ src/sfsp_out_queue.sv @@
// ----------------------------------------------------------------------------
// Frame parser result queue
// Four-entry result register queue, up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module sfsp_out_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sfsp_pkg::res_pair_t  push_i,
  output logic                 room_o,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sfsp_pkg::out_item_t  out_data
);
  import sfsp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  out_item_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic [PTR_W-1:0] wr_ptr_p1;
  logic             pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign room_o    = (count_r <= CNT_W'(QUEUE_DEPTH - 2));
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_p1 = wr_ptr_r + PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_i.first_valid) + PTR_W'(push_i.second_valid);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(push_i.first_valid) + CNT_W'(push_i.second_valid)
                 - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i.first_valid) begin
      mem_r[wr_ptr_r] <= push_i.first_item;
    end
    if (push_i.second_valid) begin
      mem_r[wr_ptr_p1] <= push_i.second_item;
    end
  end

endmodule

@@ src/sync_frame_stream_parser.sv @@
// ----------------------------------------------------------------------------
// Sync frame stream parser
// Byte-serial parser for inventory and want/held frame layouts.
// ----------------------------------------------------------------------------
// One frame byte is taken per cycle. Each byte is parsed in the cycle it is
// accepted and yields zero, one or two result transactions (a field or id
// byte, and a verdict when the frame closes or fails), which are written
// into a four-entry result queue and leave it in order on the output port.
// The input sustains one byte per cycle as long as the queue drains; it
// stalls while fewer than two queue entries are free, so the sustained rate
// is set by the result port, one result per cycle when not stalled. After an
// error the remaining bytes of the frame are dropped without results.
// Configuration writes are always ready and take effect on the next byte;
// the layout select is sampled at each frame's first byte.
module sync_frame_stream_parser #(
  parameter int COUNT_LIMIT     = 65535,
  parameter int ID_LENGTH_LIMIT = 1023
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sfsp_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sfsp_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  sfsp_pkg::cfg_index_t              cfg_index,
  input  logic [sfsp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sfsp_pkg::*;

  res_pair_t push;
  logic      room;
  logic      take;

  assign in_stall  = !room;
  assign take      = in_valid && room;
  assign cfg_ready = 1'b1;

  sfsp_core #(
    .COUNT_LIMIT     (COUNT_LIMIT),
    .ID_LENGTH_LIMIT (ID_LENGTH_LIMIT)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .take_i      (take),
    .item_i      (in_data),
    .cfg_we_i    (cfg_valid && cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .push_o      (push)
  );

  sfsp_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (push),
    .room_o    (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ src/sfsp_checker.sv @@
// ----------------------------------------------------------------------------
// Frame parser checker
// Port-level checks on result transactions, bound to the parser top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfsp_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input sfsp_pkg::out_item_t  out_data
);
  import sfsp_pkg::*;

  `SFSP_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")
  `SFSP_ASSERT(a_last_on_verdict, clk, rst_n, out_valid |-> (out_data.frame_last == ((out_data.field_kind == FK_VERDICT_OK) || (out_data.field_kind == FK_VERDICT_ERR))), "frame_last not on verdict")
  `SFSP_ASSERT(a_cause_on_error, clk, rst_n, out_valid && (out_data.error_cause != CAUSE_NONE) |-> (out_data.field_kind == FK_VERDICT_ERR), "error cause on non-error item")
  `SFSP_ASSERT(a_empty_after_rst, clk, rst_n, $past(!rst_n) |-> !out_valid, "result valid right after reset")

endmodule

bind sync_frame_stream_parser sfsp_checker u_sfsp_checker (.*);

@@ bench/tb_sync_frame_stream_parser.sv @@
// ----------------------------------------------------------------------------
// Frame parser testbench
// Sends inventory and want frames one byte per transaction into the parser and
// checks every result transaction against a cycle-free model of the parser
// that runs on each accepted byte. Directed tests cover the field extremes,
// both layouts, every error verdict and the register limits. A holdoff test
// fills the result queue. Random frames follow, mostly well formed with some
// broken ones and some noise, under several register settings.
// ----------------------------------------------------------------------------
module tb_sync_frame_stream_parser;
  import sfsp_pkg::*;

  localparam int RANDOM_BYTES   = 1320;
  localparam int RANDOM_PHASES  = 6;
  localparam int HOLDOFF_CYCLES = 200;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_LIMIT    = 5000;

  typedef enum logic [3:0] {
    ST_START, ST_FORMAT, ST_ICOUNT, ST_ILEN, ST_IBYTES, ST_ISTATE, ST_ITS,
    ST_WCOUNT, ST_HCOUNT, ST_WLEN, ST_WBYTES, ST_DONE
  } ps_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index = CFG_FRAME_KIND;
  logic [15:0] cfg_data = '0;

  // register shadow
  logic        cfg_kind = 1'b0;
  logic [15:0] cfg_max_entries = MAX_ENTRIES_RST;
  logic [15:0] cfg_max_list_ids = MAX_LIST_IDS_RST;
  logic [9:0]  cfg_max_id_len = MAX_ID_LENGTH_RST;

  // parser model state
  ps_phase_t    ps_phase = ST_START;
  logic [2:0]   ps_byte_cnt = '0;
  logic [63:0]  ps_acc = '0;
  logic [15:0]  ps_items_left = '0;
  logic [9:0]   ps_id_left = '0;
  logic [15:0]  ps_index = '0;
  logic         ps_held = 1'b0;
  logic         ps_dropping = 1'b0;

  out_item_t   fields_due[$];
  logic [7:0]  frame_buf[$];
  int          fail_count = 0;
  int          bytes_sent = 0;
  bit          idle_on = 1'b1;
  int          holdoff_req = 0;
  int          holdoff_seen = 0;
  int          holdoff_left = 0;

  sync_frame_stream_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void append_byte(input logic [7:0] b);
    frame_buf.insert(frame_buf.size(), b);
  endfunction

  function automatic void push_field(input field_kind_t kind, input logic [63:0] value,
                                     input logic [15:0] idx, input logic held,
                                     input error_cause_t cause);
    out_item_t f;
    f.field_kind   = kind;
    f.field_value  = value;
    f.entry_index  = idx;
    f.in_held_list = held;
    f.error_cause  = cause;
    f.frame_last   = (kind == FK_VERDICT_OK) || (kind == FK_VERDICT_ERR);
    fields_due.insert(fields_due.size(), f);
  endfunction

  function automatic void restart_parse();
    ps_phase      = ST_START;
    ps_byte_cnt   = '0;
    ps_acc        = '0;
    ps_items_left = '0;
    ps_id_left    = '0;
    ps_index      = '0;
    ps_held       = 1'b0;
  endfunction

  function automatic bit field_done(input int width);
    if (int'(ps_byte_cnt) + 1 < width) begin
      ps_byte_cnt = ps_byte_cnt + 3'd1;
      return 1'b0;
    end
    ps_byte_cnt = '0;
    return 1'b1;
  endfunction

  function automatic void finish_entry(input bit inventory);
    ps_index      = ps_index + 16'd1;
    ps_items_left = ps_items_left - 16'd1;
    if (ps_items_left == 0) begin
      ps_phase = (inventory || ps_held) ? ST_DONE : ST_HCOUNT;
    end else begin
      ps_phase = inventory ? ST_ILEN : ST_WLEN;
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic last);
    error_cause_t cause;
    logic [31:0]  word;
    logic [15:0]  lim;
    bit           held;
    bit           inventory;
    cause = CAUSE_NONE;
    if (ps_dropping) begin
      if (last) begin
        ps_dropping = 1'b0;
        restart_parse();
      end
      return;
    end
    if (ps_phase == ST_START) begin
      restart_parse();
      ps_phase = cfg_kind ? ST_WCOUNT : ST_FORMAT;
    end
    if (ps_phase == ST_DONE) begin
      cause = CAUSE_TRAILING;
    end else begin
      ps_acc = {ps_acc[55:0], b};
      case (ps_phase)
        ST_FORMAT: begin
          push_field(FK_FORMAT, 64'(b), '0, 1'b0, CAUSE_NONE);
          ps_acc   = '0;
          ps_phase = ST_ICOUNT;
        end
        ST_ICOUNT, ST_WCOUNT, ST_HCOUNT: begin
          if (field_done(4)) begin
            word   = ps_acc[31:0];
            held   = (ps_phase == ST_HCOUNT);
            lim    = (ps_phase == ST_ICOUNT) ? cfg_max_entries : cfg_max_list_ids;
            ps_acc = '0;
            push_field(held ? FK_HELD_COUNT : FK_COUNT, 64'(word), '0, held, CAUSE_NONE);
            if (word > 32'(lim)) begin
              cause = CAUSE_OVER_CNT;
            end else begin
              ps_held       = held;
              ps_items_left = word[15:0];
              ps_index      = '0;
              if (word == 0) begin
                ps_phase = (ps_phase == ST_WCOUNT) ? ST_HCOUNT : ST_DONE;
              end else begin
                ps_phase = (ps_phase == ST_ICOUNT) ? ST_ILEN : ST_WLEN;
              end
            end
          end
        end
        ST_ILEN, ST_WLEN: begin
          if (field_done(4)) begin
            word      = ps_acc[31:0];
            inventory = (ps_phase == ST_ILEN);
            ps_acc    = '0;
            push_field(FK_ID_LENGTH, 64'(word), ps_index, ps_held, CAUSE_NONE);
            if (word > 32'(cfg_max_id_len)) begin
              cause = CAUSE_ID_LONG;
            end else begin
              ps_id_left = word[9:0];
              if (word != 0) begin
                ps_phase = inventory ? ST_IBYTES : ST_WBYTES;
              end else if (inventory) begin
                ps_phase = ST_ISTATE;
              end else begin
                finish_entry(1'b0);
              end
            end
          end
        end
        ST_IBYTES, ST_WBYTES: begin
          ps_acc = '0;
          push_field(FK_ID_BYTE, 64'(b), ps_index, ps_held, CAUSE_NONE);
          ps_id_left = ps_id_left - 10'd1;
          if (ps_id_left == 0) begin
            if (ps_phase == ST_IBYTES) ps_phase = ST_ISTATE;
            else finish_entry(1'b0);
          end
        end
        ST_ISTATE: begin
          ps_acc = '0;
          push_field(FK_ENTRY_STATE, 64'(b), ps_index, 1'b0, CAUSE_NONE);
          ps_phase = ST_ITS;
        end
        ST_ITS: begin
          if (field_done(8)) begin
            push_field(FK_TIMESTAMP, ps_acc, ps_index, 1'b0, CAUSE_NONE);
            ps_acc = '0;
            finish_entry(1'b1);
          end
        end
        default: cause = CAUSE_TRAILING;
      endcase
    end
    if (cause != CAUSE_NONE) begin
      push_field(FK_VERDICT_ERR, '0, '0, 1'b0, cause);
      if (!last) ps_dropping = 1'b1;
      restart_parse();
    end else if (last) begin
      if (ps_phase == ST_DONE) push_field(FK_VERDICT_OK, '0, '0, 1'b0, CAUSE_NONE);
      else push_field(FK_VERDICT_ERR, '0, '0, 1'b0, CAUSE_TRUNCATED);
      restart_parse();
    end
  endfunction

  function automatic void check_field(input out_item_t got);
    out_item_t want;
    if (fields_due.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result: kind %0d value %h index %0d held %b cause %0d last %b",
                 got.field_kind, got.field_value, got.entry_index, got.in_held_list,
                 got.error_cause, got.frame_last);
      return;
    end
    want = fields_due.pop_front();
    if (got.field_kind !== want.field_kind || got.field_value !== want.field_value ||
        got.entry_index !== want.entry_index || got.in_held_list !== want.in_held_list ||
        got.error_cause !== want.error_cause || got.frame_last !== want.frame_last) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("mismatch: expected kind %0d value %h index %0d held %b cause %0d last %b",
                 want.field_kind, want.field_value, want.entry_index, want.in_held_list,
                 want.error_cause, want.frame_last);
        $display("          actual   kind %0d value %h index %0d held %b cause %0d last %b",
                 got.field_kind, got.field_value, got.entry_index, got.in_held_list,
                 got.error_cause, got.frame_last);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) parse_byte(in_data.data_byte, in_data.frame_end);
      if (out_valid && !out_stall) check_field(out_data);
    end
  end

  always @(posedge clk) begin
    if (holdoff_req != holdoff_seen) begin
      holdoff_seen <= holdoff_req;
      holdoff_left <= HOLDOFF_CYCLES;
      out_stall    <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(0, 99) < 11);
    end
  end

  function automatic void add_be(input logic [63:0] value, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) append_byte(value[8*i +: 8]);
  endfunction

  function automatic void add_random(input int nbytes);
    repeat (nbytes) append_byte(8'($urandom));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && ($urandom_range(0, 99) < 11)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, frame_end: last};
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_frame(input bit close);
    for (int i = 0; i < frame_buf.size(); i++)
      send_byte(frame_buf[i], close && (i == frame_buf.size() - 1));
    frame_buf.delete();
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (fields_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FRAME_KIND:    cfg_kind = value[0];
      CFG_MAX_ENTRIES:   cfg_max_entries = value;
      CFG_MAX_LIST_IDS:  cfg_max_list_ids = value;
      CFG_MAX_ID_LENGTH: cfg_max_id_len = value[9:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic kind, input logic [15:0] entries,
                            input logic [15:0] lists, input logic [15:0] id_len);
    settle();
    write_reg(CFG_FRAME_KIND, 16'(kind));
    write_reg(CFG_MAX_ENTRIES, entries);
    write_reg(CFG_MAX_LIST_IDS, lists);
    write_reg(CFG_MAX_ID_LENGTH, id_len);
    cfg_valid <= 1'b0;
  endtask

  function automatic void build_frame(input bit over_cnt, input bit long_id);
    int          lists;
    int          cnt;
    int          len;
    int          cap;
    logic [31:0] lim;
    bit          long_pending;
    long_pending = long_id;
    lists = cfg_kind ? 2 : 1;
    if (!cfg_kind) add_random(1);
    for (int l = 0; l < lists; l++) begin
      lim = cfg_kind ? 32'(cfg_max_list_ids) : 32'(cfg_max_entries);
      if (over_cnt && (l == lists - 1 || $urandom_range(0, 1) == 0)) begin
        if (lim == 32'hFFFF || $urandom_range(0, 3) == 0)
          add_be({16'($urandom_range(1, 65535)), 16'($urandom)}, 4);
        else
          add_be(lim + 32'd1 + 32'($urandom_range(0, 2)), 4);
        add_random($urandom_range(0, 3));
        return;
      end
      cnt = $urandom_range(0, (lim < 3) ? lim : 3);
      add_be(cnt, 4);
      for (int i = 0; i < cnt; i++) begin
        if (long_pending) begin
          if ($urandom_range(0, 1) == 0)
            add_be({16'($urandom_range(1, 65535)), 16'($urandom)}, 4);
          else
            add_be(32'(cfg_max_id_len) + 32'd1 + 32'($urandom_range(0, 2)), 4);
          add_random($urandom_range(0, 3));
          return;
        end
        cap = ($urandom_range(0, 7) == 0) ? 40 : 5;
        if (cap > int'(cfg_max_id_len)) cap = int'(cfg_max_id_len);
        len = $urandom_range(0, cap);
        add_be(len, 4);
        add_random(len);
        if (!cfg_kind) add_random(9);
      end
    end
  endfunction

  function automatic void build_random_frame();
    int roll;
    int keep;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      add_random($urandom_range(1, 12));
      return;
    end
    build_frame(roll < 13, roll >= 13 && roll < 19);
    if (roll >= 19 && roll < 29 && frame_buf.size() > 1) begin
      keep = $urandom_range(1, frame_buf.size() - 1);
      while (frame_buf.size() > keep) frame_buf.delete(frame_buf.size() - 1);
    end else if (roll >= 29 && roll < 36) begin
      add_random($urandom_range(1, 3));
    end
  endfunction

  task automatic test_inventory_layout();
    append_byte(8'hFF);
    add_be(1, 4);
    add_be(2, 4);
    append_byte(8'h00);
    append_byte(8'hFF);
    append_byte(8'h00);
    add_be(64'hFFFF_FFFF_FFFF_FFFF, 8);
    send_frame(1'b1);
    append_byte(8'h00);
    add_be(0, 4);
    send_frame(1'b1);
    settle();
  endtask

  task automatic test_error_verdicts();
    append_byte(8'h01);
    add_be(32'd1025, 4);
    add_be(24'h00AABB, 3);
    send_frame(1'b1);
    append_byte(8'h02);
    add_be(32'hFFFF_FFFF, 4);
    send_frame(1'b1);
    append_byte(8'h03);
    add_be(1, 4);
    add_be(32'd601, 4);
    add_be(16'hCDEF, 2);
    send_frame(1'b1);
    append_byte(8'h04);
    send_frame(1'b1);
    append_byte(8'h05);
    add_be(1, 4);
    add_be(0, 4);
    append_byte(8'h7E);
    add_be(24'h123456, 3);
    send_frame(1'b1);
    append_byte(8'h06);
    add_be(0, 4);
    append_byte(8'h77);
    send_frame(1'b1);
    append_byte(8'h07);
    add_be(0, 4);
    add_be(16'h8899, 2);
    send_frame(1'b1);
    settle();
  endtask

  task automatic test_want_layout();
    set_config(1'b1, MAX_ENTRIES_RST, MAX_LIST_IDS_RST, 16'(MAX_ID_LENGTH_RST));
    add_be(1, 4);
    add_be(1, 4);
    append_byte(8'h5A);
    add_be(2, 4);
    add_be(0, 4);
    add_be(2, 4);
    append_byte(8'h00);
    append_byte(8'hFF);
    send_frame(1'b1);
    add_be(0, 8);
    send_frame(1'b1);
    add_be(0, 4);
    add_be(32'd257, 4);
    add_be(1, 4);
    send_frame(1'b1);
    settle();
  endtask

  task automatic test_config_limits();
    set_config(1'b0, MAX_ENTRIES_RST, MAX_LIST_IDS_RST, 16'(MAX_ID_LENGTH_RST));
    append_byte(8'h3C);
    add_be(0, 2);
    send_frame(1'b0);
    set_config(1'b1, MAX_ENTRIES_RST, MAX_LIST_IDS_RST, 16'(MAX_ID_LENGTH_RST));
    add_be(0, 2);
    send_frame(1'b1);
    add_be(0, 8);
    send_frame(1'b1);
    set_config(1'b1, 16'd0, 16'd0, 16'd0);
    add_be(1, 4);
    send_frame(1'b1);
    add_be(0, 4);
    add_be(1, 4);
    add_be(0, 4);
    send_frame(1'b1);
    set_config(1'b0, 16'd0, 16'd0, 16'd0);
    append_byte(8'h10);
    add_be(0, 4);
    send_frame(1'b1);
    set_config(1'b0, 16'd1, 16'd0, 16'd0);
    append_byte(8'h11);
    add_be(1, 4);
    add_be(1, 4);
    append_byte(8'h11);
    send_frame(1'b1);
    append_byte(8'h12);
    add_be(1, 4);
    add_be(0, 4);
    append_byte(8'h80);
    add_be(0, 8);
    send_frame(1'b1);
    set_config(1'b0, 16'hFFFF, 16'hFFFF, 16'h03FF);
    append_byte(8'h13);
    add_be(32'hFFFF, 4);
    add_be(32'h3FF, 4);
    send_frame(1'b1);
    append_byte(8'h14);
    add_be(32'h1_0000, 4);
    send_frame(1'b1);
    append_byte(8'h15);
    add_be(1, 4);
    add_be(32'h400, 4);
    send_frame(1'b1);
    set_config(1'b1, 16'hFFFF, 16'hFFFF, 16'h03FF);
    add_be(32'hFFFF, 4);
    add_be(32'h3FF, 4);
    send_frame(1'b1);
    settle();
  endtask

  task automatic test_output_holdoff();
    set_config(1'b0, MAX_ENTRIES_RST, MAX_LIST_IDS_RST, 16'(MAX_ID_LENGTH_RST));
    holdoff_req <= holdoff_req + 1;
    append_byte(8'h42);
    add_be(3, 4);
    repeat (3) begin
      add_be(5, 4);
      add_random(5);
      add_random(1);
      add_be({$urandom, $urandom}, 8);
    end
    send_frame(1'b1);
    settle();
  endtask

  task automatic test_random_frames();
    int quota;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_config(1'b0, MAX_ENTRIES_RST, MAX_LIST_IDS_RST, 16'(MAX_ID_LENGTH_RST));
        1: set_config(1'b1, MAX_ENTRIES_RST, MAX_LIST_IDS_RST, 16'(MAX_ID_LENGTH_RST));
        2: set_config(1'($urandom_range(0, 1)), 16'($urandom_range(0, 3)),
                      16'($urandom_range(0, 3)), 16'($urandom_range(0, 8)));
        3: set_config(1'($urandom_range(0, 1)), 16'd0, 16'd0, 16'd0);
        4: set_config(1'b0, 16'hFFFF, 16'hFFFF, 16'h03FF);
        default: set_config(1'b1, 16'hFFFF, 16'hFFFF, 16'h03FF);
      endcase
      idle_on = (ph != 1);
      quota = bytes_sent + RANDOM_BYTES / RANDOM_PHASES;
      while (bytes_sent < quota) begin
        build_random_frame();
        send_frame(1'b1);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    int waited;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_inventory_layout();
    test_error_verdicts();
    test_want_layout();
    test_config_limits();
    test_output_holdoff();
    test_random_frames();
    in_valid <= 1'b0;
    for (waited = 0; waited < DRAIN_LIMIT && fields_due.size() != 0; waited++)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (fields_due.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
